// ----- rtl/gmsb_pkg.sv -----
package gmsb_pkg;

    localparam int KIND_W = 2;
    localparam int DIST_W = 6;

    // Cell contents; the fourth code is an obstacle and is never entered
    localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd0;
    localparam logic [KIND_W-1:0] KIND_BLACK = 2'd1;
    localparam logic [KIND_W-1:0] KIND_WHITE = 2'd2;

    typedef logic [2:0]        t_dir;
    typedef logic signed [1:0] t_step;

    // King-move offsets, scanned in a fixed order
    function automatic t_step step_row(input t_dir k);
        case (k) inside
            3'd0, 3'd1, 3'd2: step_row = -2'sd1;
            3'd3, 3'd4:       step_row = 2'sd0;
            default:          step_row = 2'sd1;
        endcase
    endfunction

    function automatic t_step step_col(input t_dir k);
        case (k) inside
            3'd0, 3'd3, 3'd5: step_col = -2'sd1;
            3'd1, 3'd6:       step_col = 2'sd0;
            default:          step_col = 2'sd1;
        endcase
    endfunction

endpackage

// ----- rtl/gmsb_in_if.sv -----
interface gmsb_in_if;
    logic                      valid;
    logic                      ready;
    logic [gmsb_pkg::KIND_W-1:0] cell_kind;
    logic                      last_cell;

    modport source (output valid, output cell_kind, output last_cell, input ready);
    modport sink (input valid, input cell_kind, input last_cell, output ready);
endinterface

// ----- rtl/gmsb_out_if.sv -----
interface gmsb_out_if;
    logic                      valid;
    logic                      ready;
    logic [gmsb_pkg::DIST_W-1:0] step_distance;
    logic                      reachable;
    logic                      last_result;

    modport source (output valid, output step_distance, output reachable,
                    output last_result, input ready);
    modport sink (input valid, input step_distance, input reachable,
                  input last_result, output ready);
endinterface

// ----- rtl/grid_multi_source_bfs_distance_unit.sv -----
// Multi-source king-move distance over a GRID_SIDE x GRID_SIDE grid.
// i_cell: one cell per transaction in row-major order; last_cell starts the
// search. o_result: one transaction per cell, row-major, last_result on the
// final cell. i_cfg_we/i_cfg_wdata set the seed colour (0 black, 1 white).
// Loading accepts one cell per cycle; i_cell.ready is high only while loading.
// After the last cell: a seed scan of the whole grid through the grid memory
// read port, then for each queued cell a queue pop, a distance read, probes of
// the eight neighbours through the one grid port, and a drain step when the
// last probe lands on the grid; then a final empty-queue check, and for each
// result a distance memory read and an output register load.
// Reset clears the sequencer, queue pointers, reached flags, seed colour and
// load position; grid contents are undefined until loaded.
// A stalled receiver holds the output register and pauses emission; the
// next grid may start loading while the final result still waits.
module grid_multi_source_bfs_distance_unit #(
    parameter int GRID_SIDE = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_wdata,
    gmsb_in_if.sink           i_cell,
    gmsb_out_if.source        o_result
);

    localparam int CELLS = GRID_SIDE * GRID_SIDE;
    localparam int RC_W  = $clog2(GRID_SIDE);
    localparam int A_W   = 2 * RC_W;
    localparam int DEPTH = 1 << A_W;
    localparam int QA_W  = $clog2(CELLS);
    localparam int CNT_W = $clog2(CELLS + 1);
    localparam logic [RC_W-1:0] LAST_RC = RC_W'(GRID_SIDE - 1);
    localparam logic [RC_W:0]   SIDE_X  = (RC_W + 1)'(GRID_SIDE);

    typedef enum logic [6:0] {
        ST_LOAD    = 7'b0000001,
        ST_SEED    = 7'b0000010,
        ST_POP     = 7'b0000100,
        ST_CUR     = 7'b0001000,
        ST_NEIGH   = 7'b0010000,
        ST_EMIT_RD = 7'b0100000,
        ST_EMIT_WR = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    logic                          r_src_colour;
    logic [RC_W-1:0]               r_row, r_col;
    logic [RC_W-1:0]               n_row, n_col;
    logic [DEPTH-1:0]              r_reached;
    logic [CNT_W-1:0]              r_head, r_tail;
    gmsb_pkg::t_dir                r_dir;
    logic [A_W-1:0]                r_cur;
    logic                          r_tst_vld, r_tst_seed;
    logic [A_W-1:0]                r_tst_addr;

    logic [gmsb_pkg::KIND_W-1:0]   r_grid_mem [DEPTH];
    logic [gmsb_pkg::KIND_W-1:0]   r_grid_rd;
    logic [gmsb_pkg::DIST_W-1:0]   r_dist_mem [DEPTH];
    logic [gmsb_pkg::DIST_W-1:0]   r_dist_rd;
    logic [A_W-1:0]                r_queue_mem [CELLS];
    logic [A_W-1:0]                r_queue_rd;

    logic                          r_out_vld, r_out_reach, r_out_last;
    logic [gmsb_pkg::DIST_W-1:0]   r_out_dist;

    logic                          w_in_acc, w_out_free, w_pos_last, w_push;
    logic                          w_q_empty, w_nb_ok, w_emit;
    logic [A_W-1:0]                w_pos, w_nb_addr, w_grid_raddr, w_dist_raddr;
    logic [gmsb_pkg::KIND_W-1:0]   w_seed_kind;
    logic [gmsb_pkg::DIST_W-1:0]   w_dist_wdata;
    gmsb_pkg::t_step               w_dr, w_dc;
    logic signed [RC_W+1:0]        w_nr, w_nc;

    assign i_cell.ready           = (r_state == ST_LOAD);
    assign o_result.valid         = r_out_vld;
    assign o_result.step_distance = r_out_dist;
    assign o_result.reachable     = r_out_reach;
    assign o_result.last_result   = r_out_last;

    assign w_in_acc   = i_cell.valid && i_cell.ready;
    assign w_out_free = !r_out_vld || o_result.ready;
    assign w_emit     = (r_state == ST_EMIT_WR) && w_out_free;
    assign w_pos      = {r_row, r_col};
    assign w_pos_last = (r_row == LAST_RC) && (r_col == LAST_RC);
    assign w_q_empty  = (r_head == r_tail);

    // Raster position shared by load, seed scan and emission
    always_comb begin
        if (r_col == LAST_RC) begin
            n_col = '0;
            n_row = (r_row == LAST_RC) ? '0 : r_row + 1'b1;
        end else begin
            n_col = r_col + 1'b1;
            n_row = r_row;
        end
    end

    // Neighbour of the current cell in direction r_dir
    always_comb begin
        w_dr      = gmsb_pkg::step_row(r_dir);
        w_dc      = gmsb_pkg::step_col(r_dir);
        w_nr      = $signed({2'b00, r_cur[A_W-1:RC_W]}) + (RC_W + 2)'(w_dr);
        w_nc      = $signed({2'b00, r_cur[RC_W-1:0]}) + (RC_W + 2)'(w_dc);
        w_nb_ok   = !w_nr[RC_W+1] && (w_nr[RC_W:0] < SIDE_X) &&
                    !w_nc[RC_W+1] && (w_nc[RC_W:0] < SIDE_X);
        w_nb_addr = {w_nr[RC_W-1:0], w_nc[RC_W-1:0]};
    end

    assign w_seed_kind  = r_src_colour ? gmsb_pkg::KIND_WHITE : gmsb_pkg::KIND_BLACK;
    assign w_grid_raddr = (r_state == ST_SEED) ? w_pos : w_nb_addr;
    assign w_dist_raddr = (r_state == ST_CUR) ? r_queue_rd : w_pos;
    assign w_dist_wdata = r_tst_seed ? '0 : r_dist_rd + 1'b1;

    // Test stage: the probed cell joins the wavefront if it holds the seed colour (seed scan) or is empty and unreached
    assign w_push = r_tst_vld &&
                    (r_tst_seed ? (r_grid_rd == w_seed_kind)
                                : (r_grid_rd == gmsb_pkg::KIND_EMPTY &&
                                   !r_reached[r_tst_addr]));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_LOAD: begin
                if (w_in_acc && i_cell.last_cell) n_state = ST_SEED;
            end
            ST_SEED: begin
                if (w_pos_last) n_state = ST_POP;
            end
            ST_POP: begin
                // wait for the pending probe so the empty check sees its push
                if (!r_tst_vld) n_state = w_q_empty ? ST_EMIT_RD : ST_CUR;
            end
            ST_CUR:     n_state = ST_NEIGH;
            ST_NEIGH: begin
                if (r_dir == 3'd7) n_state = ST_POP;
            end
            ST_EMIT_RD: n_state = ST_EMIT_WR;
            ST_EMIT_WR: begin
                if (w_out_free) n_state = w_pos_last ? ST_LOAD : ST_EMIT_RD;
            end
            default:    n_state = ST_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_LOAD;
            r_src_colour <= 1'b0;
            r_row        <= '0;
            r_col        <= '0;
            r_reached    <= '0;
            r_head       <= '0;
            r_tail       <= '0;
            r_dir        <= '0;
            r_tst_vld    <= 1'b0;
            r_out_vld    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_src_colour <= i_cfg_wdata;

            if (w_in_acc) begin
                if (i_cell.last_cell) begin
                    r_row     <= '0;
                    r_col     <= '0;
                    r_reached <= '0;
                    r_head    <= '0;
                    r_tail    <= '0;
                end else begin
                    r_row <= n_row;
                    r_col <= n_col;
                end
            end else if (r_state == ST_SEED || w_emit) begin
                r_row <= n_row;
                r_col <= n_col;
            end

            if (w_push) begin
                r_reached[r_tst_addr] <= 1'b1;
                r_tail                <= r_tail + 1'b1;
            end
            if (r_state == ST_POP && !r_tst_vld && !w_q_empty) r_head <= r_head + 1'b1;

            if (r_state == ST_CUR) r_dir <= '0;
            else if (r_state == ST_NEIGH) r_dir <= r_dir + 1'b1;

            r_tst_vld <= (r_state == ST_SEED) || (r_state == ST_NEIGH && w_nb_ok);

            if (w_emit) r_out_vld <= 1'b1;
            else if (o_result.ready) r_out_vld <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_tst_seed <= (r_state == ST_SEED);
        r_tst_addr <= w_grid_raddr;
        if (r_state == ST_CUR) r_cur <= r_queue_rd;
        if (w_emit) begin
            r_out_reach <= r_reached[w_pos];
            r_out_dist  <= r_reached[w_pos] ? r_dist_rd : '0;
            r_out_last  <= w_pos_last;
        end
    end

    // Grid memory: written while loading, probed during the search
    always_ff @(posedge i_clk) begin
        if (w_in_acc) r_grid_mem[w_pos] <= i_cell.cell_kind;
        if (r_state == ST_SEED || (r_state == ST_NEIGH && w_nb_ok)) begin
            r_grid_rd <= r_grid_mem[w_grid_raddr];
        end
    end

    // Distance memory: unreached entries are masked by r_reached on the way out
    always_ff @(posedge i_clk) begin
        if (w_push) r_dist_mem[r_tst_addr] <= w_dist_wdata;
        if (r_state == ST_CUR || r_state == ST_EMIT_RD) begin
            r_dist_rd <= r_dist_mem[w_dist_raddr];
        end
    end

    // Frontier queue: each cell is pushed at most once, so it never overflows
    always_ff @(posedge i_clk) begin
        if (w_push) r_queue_mem[r_tail[QA_W-1:0]] <= r_tst_addr;
        if (r_state == ST_POP && !r_tst_vld && !w_q_empty) begin
            r_queue_rd <= r_queue_mem[r_head[QA_W-1:0]];
        end
    end

`ifndef SYNTH
    a_head_le_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head <= r_tail)
        else $error("frontier queue read past its tail");

    a_push_fresh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !r_reached[r_tst_addr])
        else $error("cell entered the wavefront twice");

    a_busy_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_cell.last_cell) |=> !i_cell.ready)
        else $error("input taken while the search is starting");
`endif

endmodule

// ----- tb/tb_grid_multi_source_bfs_distance_unit.sv -----
module tb_grid_multi_source_bfs_distance_unit;

    localparam int KIND_W        = gmsb_pkg::KIND_W;
    localparam int DIST_W        = gmsb_pkg::DIST_W;
    localparam int GRID_SIDE     = 8;
    localparam int GRID_CELLS    = GRID_SIDE * GRID_SIDE;
    localparam int IDLE_PCT      = 26;
    localparam int SETTLE_CYCLES = 16;
    localparam int RANDOM_CELLS  = 80;
    localparam int TIMEOUT       = 2_000_000;

    localparam logic [KIND_W-1:0] KIND_WALL = 2'd3;
    localparam logic COLOUR_BLACK = 1'b0;
    localparam logic COLOUR_WHITE = 1'b1;

    typedef struct packed {
        logic [DIST_W-1:0] step_distance;
        logic              reachable;
        logic              last_result;
    } t_cell_result;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_wdata;

    gmsb_in_if  cell_bus ();
    gmsb_out_if result_bus ();

    grid_multi_source_bfs_distance_unit #(
        .GRID_SIDE (GRID_SIDE)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cell      (cell_bus),
        .o_result    (result_bus)
    );

    // Shadow of the block: board contents, seed colour, next load slot
    logic [KIND_W-1:0] board_kind [GRID_CELLS];
    logic              seed_colour = COLOUR_BLACK;
    int unsigned       load_index  = 0;

    t_cell_result pending_results [$];
    t_cell_result want;

    int unsigned fail_count      = 0;
    int unsigned cells_sent      = 0;
    int unsigned searches_run    = 0;
    int unsigned results_checked = 0;
    bit          calm            = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT);
        $display("TEST FAILED");
        $finish;
    end

    // Breadth-first wavefront from every seed cell over empty cells
    function automatic void predict_distances();
        int unsigned       hops [GRID_CELLS];
        bit                lit [GRID_CELLS];
        int                frontier [GRID_CELLS];
        int                head;
        int                tail;
        int                cur;
        int                row;
        int                col;
        int                nrow;
        int                ncol;
        int                nb;
        logic [KIND_W-1:0] seed_kind;
        t_cell_result      res;
        seed_kind = (seed_colour == COLOUR_WHITE) ? gmsb_pkg::KIND_WHITE
                                                  : gmsb_pkg::KIND_BLACK;
        head = 0;
        tail = 0;
        for (int i = 0; i < GRID_CELLS; i++) begin
            hops[i] = 0;
            lit[i]  = (board_kind[i] == seed_kind);
            if (lit[i]) begin
                frontier[tail] = i;
                tail++;
            end
        end
        while (head < tail) begin
            cur = frontier[head];
            head++;
            row = cur / GRID_SIDE;
            col = cur % GRID_SIDE;
            for (int dr = -1; dr <= 1; dr++) begin
                for (int dc = -1; dc <= 1; dc++) begin
                    nrow = row + dr;
                    ncol = col + dc;
                    if ((dr != 0 || dc != 0) && nrow >= 0 && ncol >= 0 &&
                        nrow < GRID_SIDE && ncol < GRID_SIDE) begin
                        nb = nrow * GRID_SIDE + ncol;
                        if (board_kind[nb] == gmsb_pkg::KIND_EMPTY && !lit[nb]) begin
                            lit[nb]  = 1'b1;
                            hops[nb] = hops[cur] + 1;
                            frontier[tail] = nb;
                            tail++;
                        end
                    end
                end
            end
        end
        for (int i = 0; i < GRID_CELLS; i++) begin
            res.step_distance = lit[i] ? DIST_W'(hops[i]) : '0;
            res.reachable     = lit[i];
            res.last_result   = (i == GRID_CELLS - 1);
            pending_results.insert(pending_results.size(), res);
        end
    endfunction

    function automatic logic [KIND_W-1:0] random_kind();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 55)      return gmsb_pkg::KIND_EMPTY;
        else if (pick < 70) return gmsb_pkg::KIND_BLACK;
        else if (pick < 85) return gmsb_pkg::KIND_WHITE;
        else                return KIND_WALL;
    endfunction

    function automatic void note_failure(string msg);
        fail_count++;
        if (fail_count <= 10) $display("MISMATCH: %s", msg);
    endfunction

    task automatic send_cell(input logic [KIND_W-1:0] kind, input logic last);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            cell_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        cell_bus.valid     <= 1'b1;
        cell_bus.cell_kind <= kind;
        cell_bus.last_cell <= last;
        @(posedge i_clk);
        while (!cell_bus.ready) @(posedge i_clk);
        board_kind[load_index] = kind;
        cells_sent++;
        if (last) begin
            predict_distances();
            searches_run++;
            load_index = 0;
        end else begin
            load_index = (load_index + 1) % GRID_CELLS;
        end
    endtask

    task automatic release_cells();
        cell_bus.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_for_drain();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write the seed colour only once the block has gone quiet
    task automatic write_colour(input logic colour);
        release_cells();
        wait_for_drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= colour;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        seed_colour = colour;
    endtask

    // Black in one corner, a full wall down column 4, white pieces on both sides
    task automatic test_reset_grid();
        int row;
        int col;
        logic [KIND_W-1:0] kind;
        write_colour(COLOUR_BLACK);
        for (int i = 0; i < GRID_CELLS; i++) begin
            row = i / GRID_SIDE;
            col = i % GRID_SIDE;
            if (i == 0)                                   kind = gmsb_pkg::KIND_BLACK;
            else if (col == 4)                            kind = KIND_WALL;
            else if (i == 7 || i == 9 || i == GRID_CELLS - 1) kind = gmsb_pkg::KIND_WHITE;
            else if (row == GRID_SIDE - 1 && col == 0)    kind = KIND_WALL;
            else                                          kind = gmsb_pkg::KIND_EMPTY;
            send_cell(kind, i == GRID_CELLS - 1);
        end
    endtask

    task automatic test_white_seeds();
        write_colour(COLOUR_WHITE);
        send_cell(gmsb_pkg::KIND_BLACK, 1'b1);
    endtask

    // Replace the only black piece with a wall: nothing seeds the search
    task automatic test_no_source();
        write_colour(COLOUR_BLACK);
        send_cell(KIND_WALL, 1'b1);
    endtask

    // Early last mark; opens the wall on row 0 so black leaks across
    task automatic test_partial_reload();
        write_colour(COLOUR_BLACK);
        send_cell(gmsb_pkg::KIND_EMPTY, 1'b0);
        send_cell(gmsb_pkg::KIND_EMPTY, 1'b0);
        send_cell(gmsb_pkg::KIND_BLACK, 1'b0);
        send_cell(gmsb_pkg::KIND_EMPTY, 1'b0);
        send_cell(gmsb_pkg::KIND_EMPTY, 1'b0);
        send_cell(gmsb_pkg::KIND_WHITE, 1'b1);
    endtask

    // Winding corridor for long distances across the grid
    task automatic test_winding_corridor();
        int row;
        int col;
        logic [KIND_W-1:0] kind;
        write_colour(COLOUR_BLACK);
        for (int i = 0; i < GRID_CELLS; i++) begin
            row = i / GRID_SIDE;
            col = i % GRID_SIDE;
            if (i == 0)
                kind = gmsb_pkg::KIND_BLACK;
            else if (row % 2 == 0)
                kind = gmsb_pkg::KIND_EMPTY;
            else if ((row % 4 == 1) ? (col == GRID_SIDE - 1) : (col == 0))
                kind = gmsb_pkg::KIND_EMPTY;
            else
                kind = KIND_WALL;
            send_cell(kind, i == GRID_CELLS - 1);
        end
    endtask

    // A full pass without a mark wraps the load slot back to the first cell
    task automatic test_wrap_without_mark();
        write_colour(COLOUR_WHITE);
        for (int i = 0; i < GRID_CELLS + 3; i++) send_cell(random_kind(), 1'b0);
        send_cell(random_kind(), 1'b1);
    endtask

    // One whole grid and its results with neither side idling
    task automatic test_no_idle();
        write_colour(COLOUR_BLACK);
        calm = 1'b1;
        for (int i = 0; i < GRID_CELLS; i++)
            send_cell(random_kind(), i == GRID_CELLS - 1);
        release_cells();
        wait_for_drain();
        calm = 1'b0;
    endtask

    task automatic test_random_grids();
        int unsigned start_cells;
        int unsigned pick;
        int unsigned count;
        logic [KIND_W-1:0] fill;
        start_cells = cells_sent;
        while (cells_sent - start_cells < RANDOM_CELLS) begin
            if ($urandom_range(2) == 0) write_colour(1'($urandom_range(1)));
            pick = $urandom_range(99);
            if (pick < 55) begin
                for (int i = 0; i < GRID_CELLS; i++)
                    send_cell(random_kind(), i == GRID_CELLS - 1);
            end else if (pick < 75) begin
                count = $urandom_range(1, GRID_CELLS - 1);
                for (int i = 0; i < count; i++) send_cell(random_kind(), i == count - 1);
            end else if (pick < 88) begin
                count = $urandom_range(1, 40);
                for (int i = 0; i < count; i++) send_cell(random_kind(), 1'b0);
            end else begin
                fill = KIND_W'($urandom_range(3));
                for (int i = 0; i < GRID_CELLS; i++) send_cell(fill, i == GRID_CELLS - 1);
            end
        end
    endtask

    // Receiver stalls at random, except during the calm stretch
    initial begin
        result_bus.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            result_bus.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && result_bus.valid && result_bus.ready) begin
            results_checked++;
            if (pending_results.size() == 0) begin
                note_failure($sformatf("unexpected result: dist %0d reach %0b last %0b",
                    result_bus.step_distance, result_bus.reachable,
                    result_bus.last_result));
            end else begin
                want = pending_results.pop_front();
                if (result_bus.step_distance !== want.step_distance ||
                    result_bus.reachable !== want.reachable ||
                    result_bus.last_result !== want.last_result) begin
                    note_failure($sformatf(
                        "result %0d: expected dist %0d reach %0b last %0b, got %0d %0b %0b",
                        results_checked, want.step_distance, want.reachable,
                        want.last_result, result_bus.step_distance,
                        result_bus.reachable, result_bus.last_result));
                end
            end
        end
    end

    initial begin
        for (int i = 0; i < GRID_CELLS; i++) board_kind[i] = gmsb_pkg::KIND_EMPTY;
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_wdata        = COLOUR_BLACK;
        cell_bus.valid     = 1'b0;
        cell_bus.cell_kind = gmsb_pkg::KIND_EMPTY;
        cell_bus.last_cell = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_grid();
        test_white_seeds();
        test_no_source();
        test_partial_reload();
        test_winding_corridor();
        test_wrap_without_mark();
        test_no_idle();
        test_random_grids();

        release_cells();
        wait_for_drain();
        $display("Ran %0d wavefront searches over %0d loaded cells, both seed colours.",
                 searches_run, cells_sent);
        $display("Checked %0d distance results, %0d failures.", results_checked, fail_count);
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
